[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the inode slot table.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define AST_IMP(lbl, clk, rst_n, ante, cons)

`define AST_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/rist_pkg.sv]
// Package for the inode slot table: slot entry type, status codes,
// request codes and disk placement helpers. No dependencies.
package rist_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int DEV_W          = 8;
    localparam int INO_W          = 24;
    localparam int REFS_W         = 16;
    localparam int START_W        = 24;
    localparam int BLOCK_W        = 25;
    localparam int POS_W          = 3;
    localparam int SLOT_OUT_W     = 6;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_LOAD      = 3'd1,
        ST_FULL      = 3'd2,
        ST_HELD      = 3'd3,
        ST_WRITEBACK = 3'd4,
        ST_CLEAN     = 3'd5,
        ST_BADPUT    = 3'd6
    } t_status;

    typedef struct packed {
        logic [DEV_W-1:0]  dev;
        logic [INO_W-1:0]  ino;
        logic [REFS_W-1:0] refs;
        logic              dirty;
    } t_slot_entry;

    localparam int ENTRY_W = $bits(t_slot_entry);

    // eight inodes per block
    function automatic logic [BLOCK_W-1:0] place_block(
        input logic [INO_W-1:0]   ino,
        input logic [START_W-1:0] start
    );
        logic [INO_W-1:0] off;
        off = ino - INO_W'(1);
        return BLOCK_W'(off[INO_W-1:3]) + BLOCK_W'(start);
    endfunction

    function automatic logic [POS_W-1:0] place_pos(input logic [INO_W-1:0] ino);
        logic [INO_W-1:0] off;
        off = ino - INO_W'(1);
        return off[POS_W-1:0];
    endfunction

endpackage

[rtl/core/refcounted_inode_slot_table_unit.sv]
// Inode slot table top level. Uses rist_pkg, rist_ram and assert_macros.svh.
// After reset a clearing pass writes every slot while the input is stalled.
// Get: one read pass over all slots, then the finishing step registers the result.
// Put: one read-modify-write of a slot; an out-of-range slot skips the read (bad put).
// One request at a time, next accepted once the result is registered; result held.
// Reset is synchronous, active low; the start register resets to 0.
`include "assert_macros.svh"

module refcounted_inode_slot_table_unit
    import rist_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [START_W-1:0]    i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [DEV_W-1:0]      i_dev_id,
    input  logic [INO_W-1:0]      i_inode_number,
    input  logic [SLOT_OUT_W-1:0] i_slot_index,
    input  logic                  i_modified,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_status,
    output logic [SLOT_OUT_W-1:0] o_slot_out,
    output logic [BLOCK_W-1:0]    o_disk_block,
    output logic [POS_W-1:0]      o_block_position
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int XW = AW + SLOT_OUT_W;
    localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_PUT_RD = 5'b01000,
        S_FIN    = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_addr;
    logic                  r_issue_done;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_rd_idx;
    logic                  r_req;
    logic [DEV_W-1:0]      r_dev;
    logic [INO_W-1:0]      r_ino;
    logic                  r_mod;
    logic [SLOT_OUT_W-1:0] r_idx6;
    logic                  r_bad;
    logic                  r_hit;
    logic [AW-1:0]         r_hit_idx;
    logic [REFS_W-1:0]     r_hit_refs;
    logic                  r_hit_dirty;
    logic                  r_free_found;
    logic [AW-1:0]         r_free_idx;
    logic [START_W-1:0]    r_start;
    logic                  r_out_valid;
    t_status               r_status;
    logic [SLOT_OUT_W-1:0] r_slot;
    logic [BLOCK_W-1:0]    r_block;
    logic [POS_W-1:0]      r_pos;

    logic                  in_acc;
    logic                  fin_go;
    logic                  rd_en;
    t_slot_entry           rd_ent;
    logic [ENTRY_W-1:0]    rd_data;
    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    t_slot_entry           ram_wr_ent;
    logic [XW-1:0]         idx_ext;
    logic                  fin_wr;
    logic [AW-1:0]         fin_addr;
    t_slot_entry           fin_ent;
    t_status               res_status;
    logic [AW-1:0]         res_idx;
    logic                  res_echo;
    logic                  res_place;
    logic [INO_W-1:0]      res_ino;
    logic [REFS_W-1:0]     dec_refs;
    logic                  put_dirty;
    logic [XW-1:0]         res_idx_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign fin_go      = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign idx_ext     = XW'(i_slot_index);
    assign rd_en       = ((r_state == S_SCAN) && !r_issue_done) || (r_state == S_PUT_RD);
    assign rd_ent      = t_slot_entry'(rd_data);

    rist_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOT_COUNT)
    ) u_slots (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ENTRY_W'(ram_wr_ent)),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_addr),
        .o_rd_data(rd_data)
    );

    // result and write-back of the finishing step
    always_comb begin
        fin_wr     = 1'b0;
        fin_addr   = r_addr;
        fin_ent    = '0;
        res_status = ST_FULL;
        res_idx    = '0;
        res_echo   = 1'b0;
        res_place  = 1'b0;
        res_ino    = r_ino;
        dec_refs   = rd_ent.refs - REFS_W'(1);
        put_dirty  = rd_ent.dirty | r_mod;
        if (r_req == REQ_GET) begin
            if (r_hit) begin
                fin_wr       = 1'b1;
                fin_addr     = r_hit_idx;
                fin_ent.dev  = r_dev;
                fin_ent.ino  = r_ino;
                fin_ent.refs = (r_hit_refs == REFS_MAX) ? r_hit_refs
                                                        : r_hit_refs + REFS_W'(1);
                fin_ent.dirty = r_hit_dirty;
                res_status   = ST_HIT;
                res_idx      = r_hit_idx;
                res_place    = 1'b1;
            end else if (r_free_found) begin
                fin_wr        = 1'b1;
                fin_addr      = r_free_idx;
                fin_ent.dev   = r_dev;
                fin_ent.ino   = r_ino;
                fin_ent.refs  = REFS_W'(1);
                fin_ent.dirty = 1'b0;
                res_status    = ST_LOAD;
                res_idx       = r_free_idx;
                res_place     = 1'b1;
            end
        end else begin
            res_echo = 1'b1;
            if (r_bad || rd_ent.refs == '0) begin
                res_status = ST_BADPUT;
            end else begin
                fin_wr       = 1'b1;
                fin_ent.dev  = rd_ent.dev;
                fin_ent.ino  = rd_ent.ino;
                fin_ent.refs = dec_refs;
                res_place    = 1'b1;
                res_ino      = rd_ent.ino;
                if (dec_refs != '0) begin
                    fin_ent.dirty = put_dirty;
                    res_status    = ST_HELD;
                end else if (put_dirty) begin
                    fin_ent.dirty = 1'b0;
                    res_status    = ST_WRITEBACK;
                end else begin
                    fin_ent.dirty = 1'b0;
                    res_status    = ST_CLEAN;
                end
            end
        end
    end

    assign res_idx_ext = XW'(res_idx);
    assign ram_wr_en   = (r_state == S_CLEAR) || (fin_go && fin_wr);
    assign ram_wr_addr = (r_state == S_CLEAR) ? r_addr : fin_addr;
    assign ram_wr_ent  = (r_state == S_CLEAR) ? t_slot_entry'('0) : fin_ent;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == REQ_GET) begin
                        n_state = S_SCAN;
                    end else if (idx_ext < XW'(SLOT_COUNT)) begin
                        n_state = S_PUT_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                if (r_rd_vld && r_rd_idx == LAST) n_state = S_FIN;
            end
            S_PUT_RD: n_state = S_FIN;
            S_FIN: begin
                if (fin_go) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_start      <= '0;
            r_out_valid  <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN) && !r_issue_done;
            if (i_cfg_valid) r_start <= i_cfg_data;
            if (r_state == S_CLEAR) begin
                r_addr <= (r_addr == LAST) ? '0 : r_addr + AW'(1);
            end
            if (in_acc) begin
                r_issue_done <= 1'b0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
                r_addr       <= (i_req_type == REQ_GET) ? '0 : idx_ext[AW-1:0];
            end
            if (r_state == S_SCAN && !r_issue_done) begin
                if (r_addr == LAST) r_issue_done <= 1'b1;
                else                r_addr       <= r_addr + AW'(1);
            end
            if (r_state == S_SCAN && r_rd_vld) begin
                if (!r_hit && rd_ent.refs != '0 && rd_ent.dev == r_dev
                        && rd_ent.ino == r_ino) begin
                    r_hit <= 1'b1;
                end
                if (!r_free_found && rd_ent.refs == '0) r_free_found <= 1'b1;
            end
            if (fin_go) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (in_acc) begin
            r_req  <= i_req_type;
            r_dev  <= i_dev_id;
            r_ino  <= i_inode_number;
            r_mod  <= i_modified;
            r_idx6 <= i_slot_index;
            r_bad  <= !(idx_ext < XW'(SLOT_COUNT));
        end
        if (r_state == S_SCAN && r_rd_vld) begin
            if (!r_hit) begin
                r_hit_idx   <= r_rd_idx;
                r_hit_refs  <= rd_ent.refs;
                r_hit_dirty <= rd_ent.dirty;
            end
            if (!r_free_found) r_free_idx <= r_rd_idx;
        end
        if (fin_go) begin
            r_status <= res_status;
            r_slot   <= res_echo ? r_idx6 : res_idx_ext[SLOT_OUT_W-1:0];
            r_block  <= res_place ? place_block(res_ino, r_start) : '0;
            r_pos    <= res_place ? place_pos(res_ino) : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_slot_out       = r_slot;
    assign o_disk_block     = r_block;
    assign o_block_position = r_pos;

    `AST_IMP(a_no_wr_in_read, i_clk, i_rst_n,
        (r_state == S_SCAN) || (r_state == S_PUT_RD), !ram_wr_en)
    `AST_NXT(a_fin_to_out, i_clk, i_rst_n, fin_go, o_out_valid && (r_state == S_IDLE))
    `AST_IMP(a_load_had_free, i_clk, i_rst_n,
        fin_go && (res_status == ST_LOAD), r_free_found && !r_hit && (r_req == REQ_GET))

endmodule

[rtl/core/rist_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module rist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[dv/tb_refcounted_inode_slot_table_unit.sv]
// Testbench for refcounted_inode_slot_table_unit: directed and random get/put beats,
// table start changes between phases, checked against an in-bench slot table model.
// Depends on rist_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_refcounted_inode_slot_table_unit;
    import rist_pkg::*;

    localparam int SLOTS      = SLOT_COUNT_DEF;
    localparam int POOL       = 48;
    localparam int IDLE_LIMIT = 3000;

    typedef struct packed {
        t_status                status;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [BLOCK_W-1:0]     block;
        logic [POS_W-1:0]       pos;
    } t_inode_result;

    class slot_table_scoreboard;
        logic [DEV_W-1:0]   slot_dev  [SLOTS];
        logic [INO_W-1:0]   slot_ino  [SLOTS];
        logic [REFS_W-1:0]  slot_refs [SLOTS];
        logic               slot_dirty[SLOTS];
        logic [START_W-1:0] table_start;
        t_inode_result      expected_q[$];
        int                 errors;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                slot_dev[i]   = '0;
                slot_ino[i]   = '0;
                slot_refs[i]  = '0;
                slot_dirty[i] = 1'b0;
            end
            table_start = '0;
            errors      = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function t_inode_result located(t_status st, int slot, logic [INO_W-1:0] ino);
            logic [INO_W-1:0] off;
            t_inode_result    r;
            off      = ino - INO_W'(1);
            r.status = st;
            r.slot   = SLOT_OUT_W'(slot);
            r.block  = BLOCK_W'(off >> 3) + BLOCK_W'(table_start);
            r.pos    = off[2:0];
            return r;
        endfunction

        function void note_request(logic req, logic [DEV_W-1:0] dev, logic [INO_W-1:0] ino,
                                   logic [SLOT_OUT_W-1:0] idx, logic modified);
            t_inode_result r;
            int            hit;
            int            free_slot;
            hit       = -1;
            free_slot = -1;
            r         = '0;
            if (req == REQ_GET) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (hit < 0 && slot_refs[i] != 0 && slot_dev[i] == dev && slot_ino[i] == ino)
                        hit = i;
                    if (free_slot < 0 && slot_refs[i] == 0)
                        free_slot = i;
                end
                if (hit >= 0) begin
                    if (slot_refs[hit] != REFS_MAX)
                        slot_refs[hit] = slot_refs[hit] + REFS_W'(1);
                    r = located(ST_HIT, hit, ino);
                end else if (free_slot >= 0) begin
                    slot_dev[free_slot]   = dev;
                    slot_ino[free_slot]   = ino;
                    slot_refs[free_slot]  = REFS_W'(1);
                    slot_dirty[free_slot] = 1'b0;
                    r = located(ST_LOAD, free_slot, ino);
                end else begin
                    r.status = ST_FULL;
                end
            end else if (int'(idx) >= SLOTS || slot_refs[idx] == 0) begin
                r.status = ST_BADPUT;
                r.slot   = idx;
            end else begin
                slot_dirty[idx] = slot_dirty[idx] | modified;
                slot_refs[idx]  = slot_refs[idx] - REFS_W'(1);
                if (slot_refs[idx] != 0) begin
                    r = located(ST_HELD, idx, slot_ino[idx]);
                end else if (slot_dirty[idx]) begin
                    slot_dirty[idx] = 1'b0;
                    r = located(ST_WRITEBACK, idx, slot_ino[idx]);
                end else begin
                    r = located(ST_CLEAN, idx, slot_ino[idx]);
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [2:0] st, logic [SLOT_OUT_W-1:0] slot,
                                   logic [BLOCK_W-1:0] block, logic [POS_W-1:0] pos);
            t_inode_result e;
            if (expected_q.size() == 0) begin
                $error("unexpected result beat: status %0d slot %0d", st, slot);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (slot !== e.slot) begin
                $error("slot_out: expected %0d, got %0d", e.slot, slot);
                errors++;
            end
            if (block !== e.block) begin
                $error("disk_block: expected 0x%0h, got 0x%0h", e.block, block);
                errors++;
            end
            if (pos !== e.pos) begin
                $error("block_position: expected %0d, got %0d", e.pos, pos);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [START_W-1:0]    i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic                  i_req_type     = REQ_GET;
    logic [DEV_W-1:0]      i_dev_id       = '0;
    logic [INO_W-1:0]      i_inode_number = '0;
    logic [SLOT_OUT_W-1:0] i_slot_index   = '0;
    logic                  i_modified     = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [2:0]            o_status;
    logic [SLOT_OUT_W-1:0] o_slot_out;
    logic [BLOCK_W-1:0]    o_disk_block;
    logic [POS_W-1:0]      o_block_position;

    slot_table_scoreboard sb = new();

    logic [DEV_W-1:0] pool_dev [POOL];
    logic [INO_W-1:0] pool_ino [POOL];
    bit               calm         = 1'b0;
    int               stall_left   = 0;
    int               free_left    = 0;
    int               idle_cycles  = 0;

    refcounted_inode_slot_table_unit #(
        .SLOT_COUNT(SLOTS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_dev_id         (i_dev_id),
        .i_inode_number   (i_inode_number),
        .i_slot_index     (i_slot_index),
        .i_modified       (i_modified),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_slot_out       (o_slot_out),
        .o_disk_block     (o_disk_block),
        .o_block_position (o_block_position)
    );

    always #2 i_clk = ~i_clk;

    // result side: random stall bursts
    always @(posedge i_clk) begin
        if (!calm && stall_left == 0 && free_left == 0) begin
            if ($urandom_range(0, 1) == 0)
                stall_left = $urandom_range(1, 14);
            else
                free_left = $urandom_range(1, 40);
        end
        if (!calm && stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = 0;
            if (free_left > 0)
                free_left--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_slot_out, o_disk_block, o_block_position);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** refcounted_inode_slot_table_unit: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_request(input logic req, input logic [DEV_W-1:0] dev,
                                input logic [INO_W-1:0] ino,
                                input logic [SLOT_OUT_W-1:0] idx, input logic modified);
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_dev_id       <= dev;
        i_inode_number <= ino;
        i_slot_index   <= idx;
        i_modified     <= modified;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_request(req, dev, ino, idx, modified);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // unused fields carry random values
    task automatic get_inode(input logic [DEV_W-1:0] dev, input logic [INO_W-1:0] ino);
        send_request(REQ_GET, dev, ino, SLOT_OUT_W'($urandom), 1'($urandom));
    endtask

    task automatic put_slot(input logic [SLOT_OUT_W-1:0] idx, input logic modified);
        send_request(REQ_PUT, DEV_W'($urandom), INO_W'($urandom), idx, modified);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_table_start(input logic [START_W-1:0] value);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.table_start = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [INO_W-1:0] rand_ino();
        case ($urandom_range(0, 3))
            0:       return INO_W'($urandom_range(1, 64));
            1:       return INO_W'($urandom);
            2:       return INO_W'(24'hFFFFFF - $urandom_range(0, 15));
            default: return INO_W'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic void refill_pool();
        pool_dev[0] = '0;
        pool_ino[0] = INO_W'(1);
        pool_dev[1] = '1;
        pool_ino[1] = '1;
        pool_dev[2] = DEV_W'($urandom);
        pool_ino[2] = '0;
        for (int k = 3; k < POOL; k++) begin
            pool_dev[k] = DEV_W'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3));
            pool_ino[k] = rand_ino();
        end
    endfunction

    task automatic random_request(input int get_pct);
        int k;
        int s;
        int first;
        s = -1;
        if ($urandom_range(0, 99) < get_pct) begin
            if ($urandom_range(0, 9) < 7) begin
                k = $urandom_range(0, POOL - 1);
                get_inode(pool_dev[k], pool_ino[k]);
            end else begin
                get_inode(DEV_W'($urandom), rand_ino());
            end
        end else begin
            if ($urandom_range(0, 99) < 85) begin
                first = $urandom_range(0, SLOTS - 1);
                for (int j = 0; j < SLOTS; j++)
                    if (s < 0 && sb.slot_refs[(first + j) % SLOTS] != 0)
                        s = (first + j) % SLOTS;
            end
            if (s < 0)
                s = $urandom_range(0, SLOTS - 1);
            put_slot(SLOT_OUT_W'(s), 1'($urandom));
        end
    endtask

    initial begin
        int               get_pct [5];
        logic [START_W-1:0] start_val;
        get_pct = '{70, 50, 90, 40, 60};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: lowest and highest keys, hit, same inode on another device,
        // write-back, clean release, puts on free slots
        get_inode(8'd0, 24'd1);
        get_inode(8'hFF, 24'hFFFFFF);
        get_inode(8'd0, 24'd1);
        get_inode(8'd1, 24'd1);
        put_slot(6'd0, 1'b1);
        put_slot(6'd0, 1'b0);
        put_slot(6'd0, 1'b0);
        put_slot(6'd63, 1'b1);
        put_slot(6'd1, 1'b0);
        get_inode(8'hAA, 24'h555555);
        get_inode(8'h55, 24'hAAAAAA);
        put_slot(6'd2, 1'b1);

        // inode zero wraps, largest table start
        write_table_start(24'hFFFFFF);
        get_inode(8'd0, 24'd0);
        get_inode(8'd0, 24'd0);
        get_inode(8'hFF, 24'hFFFFFF);
        put_slot(6'd2, 1'b0);
        put_slot(6'd2, 1'b0);
        put_slot(6'd3, 1'b1);
        put_slot(6'd0, 1'b1);
        put_slot(6'd1, 1'b0);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       start_val = 24'h000000;
                1:       start_val = 24'hFFFFFF;
                3:       start_val = 24'h000001;
                default: start_val = START_W'($urandom);
            endcase
            write_table_start(start_val);
            refill_pool();
            for (int n = 0; n < 225; n++) begin
                if (p == 4 && n >= 125)
                    calm = 1'b1;
                random_request(get_pct[p]);
                if (p == 1 && n == 100)
                    drain();
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** refcounted_inode_slot_table_unit: PASSED **");
        else
            $display("** refcounted_inode_slot_table_unit: FAILED **");
        $finish;
    end

endmodule
